### hdl/gol_pkg.sv
`default_nettype none

package gol_pkg;

    localparam int ROW_W          = 32;
    localparam int POP_W          = 6;
    localparam int TOT_W          = 16;
    localparam int GRID_WIDTH_DEF = 32;
    localparam int RECV_W         = 2;
    localparam int RQ_DEPTH       = 4;
    localparam int RQ_AW          = $clog2(RQ_DEPTH);
    localparam int RQ_CW          = $clog2(RQ_DEPTH + 1);

    localparam logic [RECV_W-1:0] RECV_MAX = RECV_W'(2);
    localparam logic [3:0]        BIRTH_N  = 4'd3;
    localparam logic [3:0]        SURV_N   = 4'd2;
    localparam logic [TOT_W-1:0]  TOT_MAX  = {TOT_W{1'b1}};

    // bits one column shows to its neighbours
    typedef struct packed {
        logic older;
        logic middle;
        logic fresh;
    } gol_nbr_t;

    // next-generation bits of one column
    typedef struct packed {
        logic mid;
        logic fin;
    } gol_next_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [POP_W-1:0] pop;
        logic             eog;
    } gol_res_t;

    typedef struct packed {
        logic push_a;
        logic push_b;
        logic pop;
    } gol_rq_ctl_t;

    typedef struct packed {
        logic head_valid;
        logic room;
    } gol_rq_stat_t;

    function automatic logic gol_rule(input logic alive, input logic [3:0] n);
        return (n == BIRTH_N) || (alive && (n == SURV_N));
    endfunction

    // adder tree, one level per loop and the last level in the return
    function automatic logic [POP_W-1:0] gol_popcount(input logic [ROW_W-1:0] v);
        logic [1:0] s1 [16];
        logic [2:0] s2 [8];
        logic [3:0] s3 [4];
        logic [4:0] s4 [2];
        for (int i = 0; i < 16; i++)
            s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        for (int i = 0; i < 8; i++)
            s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        for (int i = 0; i < 4; i++)
            s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        for (int i = 0; i < 2; i++)
            s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        return {1'b0, s4[0]} + {1'b0, s4[1]};
    endfunction

endpackage

`default_nettype wire

### hdl/gol_row_if.sv
`default_nettype none

interface gol_row_if;
    import gol_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_bits;
    logic             last_row;

    modport source (output valid, output row_bits, output last_row, input ready);
    modport sink (input valid, input row_bits, input last_row, output ready);
endinterface

`default_nettype wire

### hdl/gol_res_if.sv
`default_nettype none

interface gol_res_if;
    import gol_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] next_row;
    logic [POP_W-1:0] row_population;
    logic [TOT_W-1:0] grid_population;
    logic             end_of_grid;

    modport source (output valid, output next_row, output row_population,
                    output grid_population, output end_of_grid, input ready);
    modport sink (input valid, input next_row, input row_population,
                  input grid_population, input end_of_grid, output ready);
endinterface

`default_nettype wire

### hdl/life_cellular_automaton_row_step.sv
// order: results pass via the result queue to the output register; a last
// row's second result follows its first; throughput: one row per cycle while
// the queue has room; a last row of a taller grid yields two result beats,
// and the four-entry result queue absorbs the extra beat while room for two remains
// reset: rst_n clears the stored rows, row count, grid total and queue,
// and the block starts a new grid
`default_nettype none

module life_cellular_automaton_row_step #(
    parameter int GRID_WIDTH = gol_pkg::GRID_WIDTH_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    gol_row_if.sink   row,
    gol_res_if.source result
);
    import gol_pkg::*;

    localparam int NCOLS = (GRID_WIDTH < ROW_W) ? GRID_WIDTH : ROW_W;

    gol_nbr_t     nbr [NCOLS+2];
    logic [ROW_W-1:0] mid_bits;
    logic [ROW_W-1:0] fin_bits;

    logic [RECV_W-1:0] recv_reg, recv_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic              out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]  out_row_reg;
    logic [POP_W-1:0]  out_pop_reg;
    logic [TOT_W-1:0]  out_grid_reg;
    logic              out_eog_reg;

    logic          take;
    gol_rq_ctl_t   q_ctl;
    gol_rq_stat_t  q_stat;
    gol_res_t      q_a;
    gol_res_t      q_b;
    gol_res_t      q_head;
    logic          load;
    logic [TOT_W:0] sum;
    logic [TOT_W-1:0] sat;

    assign take      = row.valid && row.ready;
    assign row.ready = q_stat.room;

    assign nbr[0]       = '0;
    assign nbr[NCOLS+1] = '0;

    for (genvar c = 0; c < NCOLS; c++)
    begin : g_col
        gol_next_t nx;

        gol_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .take  (take),
            .last  (row.last_row),
            .fresh (row.row_bits[c]),
            .left  (nbr[c]),
            .right (nbr[c+2]),
            .self  (nbr[c+1]),
            .nxt   (nx)
        );

        assign mid_bits[c] = nx.mid;
        assign fin_bits[c] = nx.fin;
    end

    for (genvar c = NCOLS; c < ROW_W; c++)
    begin : g_pad
        assign mid_bits[c] = 1'b0;
        assign fin_bits[c] = 1'b0;
    end

    always_comb
    begin
        recv_next = recv_reg;
        if (take)
        begin
            if (row.last_row)
                recv_next = '0;
            else if (recv_reg < RECV_MAX)
                recv_next = recv_reg + RECV_W'(1);
        end
    end

    always_comb
    begin
        q_a.row      = mid_bits;
        q_a.pop      = gol_popcount(mid_bits);
        q_a.eog      = 1'b0;
        q_b.row      = fin_bits;
        q_b.pop      = gol_popcount(fin_bits);
        q_b.eog      = 1'b1;
        q_ctl.push_a = take && (recv_reg != '0);
        q_ctl.push_b = take && row.last_row;
        q_ctl.pop    = load;
    end

    gol_rq u_rq (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (q_ctl),
        .entry_a (q_a),
        .entry_b (q_b),
        .head    (q_head),
        .stat    (q_stat)
    );

    // output register and running grid total
    always_comb
    begin
        load           = q_stat.head_valid && (!out_valid_reg || result.ready);
        sum            = {1'b0, total_reg} + (TOT_W + 1)'(q_head.pop);
        sat            = sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];
        out_valid_next = load || (out_valid_reg && !result.ready);
        total_next     = total_reg;
        if (load)
            total_next = q_head.eog ? '0 : sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recv_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            recv_reg      <= recv_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_row_reg  <= q_head.row;
            out_pop_reg  <= q_head.pop;
            out_grid_reg <= sat;
            out_eog_reg  <= q_head.eog;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.next_row        = out_row_reg;
    assign result.row_population  = out_pop_reg;
    assign result.grid_population = out_grid_reg;
    assign result.end_of_grid     = out_eog_reg;

endmodule

`default_nettype wire

### hdl/gol_cell.sv
`default_nettype none

module gol_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire logic              last,
    input  wire logic              fresh,
    input  wire gol_pkg::gol_nbr_t left,
    input  wire gol_pkg::gol_nbr_t right,
    output gol_pkg::gol_nbr_t      self,
    output gol_pkg::gol_next_t     nxt
);
    import gol_pkg::*;

    logic older_reg, older_next;
    logic middle_reg, middle_next;
    logic [3:0] n_mid;
    logic [3:0] n_fin;

    always_comb
    begin
        older_next  = older_reg;
        middle_next = middle_reg;
        if (take)
        begin
            // end of grid clears the column back to a dead border
            older_next  = last ? 1'b0 : middle_reg;
            middle_next = last ? 1'b0 : fresh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg  <= 1'b0;
            middle_reg <= 1'b0;
        end
        else
        begin
            older_reg  <= older_next;
            middle_reg <= middle_next;
        end
    end

    assign self.older  = older_reg;
    assign self.middle = middle_reg;
    assign self.fresh  = fresh;

    always_comb
    begin
        n_mid = {3'b0, left.older} + {3'b0, older_reg} + {3'b0, right.older}
              + {3'b0, left.middle} + {3'b0, right.middle}
              + {3'b0, left.fresh} + {3'b0, fresh} + {3'b0, right.fresh};
        // row below the last one is dead
        n_fin = {3'b0, left.middle} + {3'b0, middle_reg} + {3'b0, right.middle}
              + {3'b0, left.fresh} + {3'b0, right.fresh};
        nxt.mid = gol_rule(middle_reg, n_mid);
        nxt.fin = gol_rule(fresh, n_fin);
    end

endmodule

`default_nettype wire

### hdl/gol_rq.sv
`default_nettype none

module gol_rq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire gol_pkg::gol_rq_ctl_t ctl,
    input  wire gol_pkg::gol_res_t    entry_a,
    input  wire gol_pkg::gol_res_t    entry_b,
    output gol_pkg::gol_res_t         head,
    output gol_pkg::gol_rq_stat_t     stat
);
    import gol_pkg::*;

    gol_res_t         mem [RQ_DEPTH];
    logic [RQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RQ_CW-1:0] count_reg, count_next;
    logic [RQ_AW-1:0] slot_b;

    // second result goes behind the first when both arrive in one beat
    assign slot_b = ctl.push_a ? (wr_ptr_reg + RQ_AW'(1)) : wr_ptr_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RQ_AW'(ctl.push_a) + RQ_AW'(ctl.push_b);
        rd_ptr_next = rd_ptr_reg + RQ_AW'(ctl.pop);
        count_next  = count_reg + RQ_CW'(ctl.push_a) + RQ_CW'(ctl.push_b)
                    - RQ_CW'(ctl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push_a)
            mem[wr_ptr_reg] <= entry_a;
        if (ctl.push_b)
            mem[slot_b] <= entry_b;
    end

    assign head            = mem[rd_ptr_reg];
    assign stat.head_valid = (count_reg != '0);
    assign stat.room       = (count_reg <= RQ_CW'(RQ_DEPTH - 2));

endmodule

`default_nettype wire

### hdl/gol_checker.sv
`default_nettype none

module gol_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      res_valid,
    input wire logic                      res_ready,
    input wire logic [gol_pkg::ROW_W-1:0] next_row,
    input wire logic [gol_pkg::POP_W-1:0] row_population,
    input wire logic [gol_pkg::TOT_W-1:0] grid_population,
    input wire logic                      end_of_grid
);
    import gol_pkg::*;

    logic             open_reg;
    logic [TOT_W-1:0] tot_reg;

    // remembers whether the last beat taken left a grid open, and its total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            tot_reg  <= '0;
        end
        else if (res_valid && res_ready)
        begin
            open_reg <= !end_of_grid;
            tot_reg  <= grid_population;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(next_row)
            && $stable(row_population) && $stable(grid_population)
            && $stable(end_of_grid))
        else $error("result beat changed while stalled");

    a_pop_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> row_population <= POP_W'(ROW_W))
        else $error("row population above row width");

    a_grid_start: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !open_reg |-> grid_population == TOT_W'(row_population))
        else $error("new grid total does not start from its first row");

    a_grid_grow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && open_reg |-> grid_population >= tot_reg)
        else $error("grid total went down within a grid");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result valid straight after reset");

endmodule

bind life_cellular_automaton_row_step gol_checker u_gol_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .next_row        (result.next_row),
    .row_population  (result.row_population),
    .grid_population (result.grid_population),
    .end_of_grid     (result.end_of_grid)
);

`default_nettype wire

### tb/life_cellular_automaton_row_step_test.sv
`timescale 1ns / 100ps

module life_cellular_automaton_row_step_test;
    import gol_pkg::*;

    localparam int COLS = (GRID_WIDTH_DEF < ROW_W) ? GRID_WIDTH_DEF : ROW_W;
    localparam logic [ROW_W-1:0] COL_MASK = {ROW_W{1'b1}} >> (ROW_W - COLS);
    localparam int RANDOM_ROWS = 340;
    localparam int HOLD_CYCLES = 300;
    localparam int STILL_ROWS  = 36;
    // 2x2 blocks with one dead column between them, a still life
    localparam logic [ROW_W-1:0] BLOCK_ROW = 32'hDB6D_B6DB;

    typedef struct packed {
        logic [ROW_W-1:0] next_row;
        logic [POP_W-1:0] row_pop;
        logic [TOT_W-1:0] grid_pop;
        logic             last;
    } life_beat_t;

    typedef struct packed {
        logic [ROW_W-1:0] bits;
        logic             last;
        logic             typed;
        life_beat_t       want;
    } dir_row_t;

    typedef enum {RX_FREE, RX_COIN, RX_SLOW} rx_mode_t;
    typedef enum {ROW_EVEN, ROW_SPARSE, ROW_DENSE, ROW_EXTREME} row_style_t;

    logic clk = 1'b0;
    logic rst_n;

    gol_row_if row_ch ();
    gol_res_if res_ch ();

    life_cellular_automaton_row_step DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .row    (row_ch.sink),
        .result (res_ch.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // the one-row grids at the top have results worked out by hand
    dir_row_t dir_rows [22] = '{
        '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 6'd0, 16'd0, 1'b1}},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, '{32'h7FFF_FFFE, 6'd30, 16'd30, 1'b1}},
        '{32'h0000_0007, 1'b1, 1'b1, '{32'h0000_0002, 6'd1, 16'd1, 1'b1}},
        '{32'h8000_0001, 1'b1, 1'b1, '{32'h0000_0000, 6'd0, 16'd0, 1'b1}},
        // blinker
        '{32'h0000_0002, 1'b0, 1'b0, '0},
        '{32'h0000_0002, 1'b0, 1'b0, '0},
        '{32'h0000_0002, 1'b1, 1'b0, '0},
        // solid grid
        '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b1, 1'b0, '0},
        // blocks in the top corners, pairs of cells in the bottom ones
        '{32'hC000_0003, 1'b0, 1'b0, '0},
        '{32'hC000_0003, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b0, 1'b0, '0},
        '{32'hC000_0003, 1'b1, 1'b0, '0},
        // birth against the top edge and the high column
        '{32'h8000_0000, 1'b0, 1'b0, '0},
        '{32'hC000_0000, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b1, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b0, 1'b0, '0},
        '{32'h5555_5555, 1'b0, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b0, 1'b0, '0},
        '{32'h5555_5555, 1'b1, 1'b0, '0}
    };

    life_beat_t       next_gen_q [$];
    logic [ROW_W-1:0] prev2_row;
    logic [ROW_W-1:0] prev1_row;
    int               rows_in;
    int               grid_total;
    int               errors;
    int               burst_left;
    bit               hold_req;

    function automatic logic [ROW_W-1:0] life_next_gen(input logic [ROW_W-1:0] up,
                                                       input logic [ROW_W-1:0] mid,
                                                       input logic [ROW_W-1:0] dn);
        logic [ROW_W+1:0] u;
        logic [ROW_W+1:0] m;
        logic [ROW_W+1:0] d;
        logic [ROW_W-1:0] nxt;
        int               n;
        // dead border on both sides, column c sits at bit c+1
        u   = {1'b0, up, 1'b0};
        m   = {1'b0, mid, 1'b0};
        d   = {1'b0, dn, 1'b0};
        nxt = '0;
        for (int c = 0; c < COLS; c++)
        begin
            n = u[c] + u[c+1] + u[c+2] + m[c] + m[c+2] + d[c] + d[c+1] + d[c+2];
            nxt[c] = (n == 3) || (m[c+1] && (n == 2));
        end
        return nxt;
    endfunction

    task automatic queue_next_gen(input logic [ROW_W-1:0] bits, input logic last);
        life_beat_t b;
        b.next_row = bits;
        b.row_pop  = POP_W'($countones(bits));
        grid_total = grid_total + $countones(bits);
        if (grid_total > int'(TOT_MAX))
            grid_total = int'(TOT_MAX);
        b.grid_pop = TOT_W'(grid_total);
        b.last     = last;
        next_gen_q.push_back(b);
    endtask

    task automatic grid_advance(input logic [ROW_W-1:0] bits, input logic last);
        logic [ROW_W-1:0] cur;
        cur = bits & COL_MASK;
        if (rows_in != 0)
            queue_next_gen(life_next_gen(prev2_row, prev1_row, cur), 1'b0);
        if (last)
        begin
            queue_next_gen(life_next_gen(prev1_row, cur, '0), 1'b1);
            prev2_row  = '0;
            prev1_row  = '0;
            rows_in    = 0;
            grid_total = 0;
        end
        else
        begin
            prev2_row = prev1_row;
            prev1_row = cur;
            if (rows_in < 2)
                rows_in++;
        end
    endtask

    task automatic report(input string msg);
        $display("mismatch @ %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_beat();
        life_beat_t w;
        if (next_gen_q.size() == 0)
        begin
            report($sformatf("unexpected beat, next_row %h", res_ch.next_row));
            return;
        end
        w = next_gen_q.pop_front();
        if (res_ch.next_row !== w.next_row)
            report($sformatf("next_row %h, want %h", res_ch.next_row, w.next_row));
        if (res_ch.row_population !== w.row_pop)
            report($sformatf("row_population %0d, want %0d",
                             res_ch.row_population, w.row_pop));
        if (res_ch.grid_population !== w.grid_pop)
            report($sformatf("grid_population %0d, want %0d",
                             res_ch.grid_population, w.grid_pop));
        if (res_ch.end_of_grid !== w.last)
            report($sformatf("end_of_grid %b, want %b", res_ch.end_of_grid, w.last));
    endtask

    task automatic send_row(input logic [ROW_W-1:0] bits, input logic last);
        row_ch.valid    <= 1'b1;
        row_ch.row_bits <= bits;
        row_ch.last_row <= last;
        @(posedge clk);
        while (!row_ch.ready)
            @(posedge clk);
        grid_advance(bits, last);
    endtask

    // bursts of back-to-back beats, then a short gap
    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            row_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 15);
        end
    endtask

    function automatic logic [ROW_W-1:0] random_row(input row_style_t style);
        case (style)
            ROW_SPARSE:  return $urandom & $urandom;
            ROW_DENSE:   return $urandom | $urandom;
            ROW_EXTREME: return ($urandom_range(0, 1) == 1) ? '1 : '0;
            default:     return $urandom;
        endcase
    endfunction

    initial
    begin : limit
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : result_side
        rx_mode_t mode;
        int       mode_left;
        int       hold;
        mode      = RX_FREE;
        mode_left = 0;
        hold      = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                check_beat();
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold     = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (mode)
                    RX_FREE: res_ch.ready <= 1'b1;
                    RX_COIN: res_ch.ready <= 1'($urandom_range(0, 1));
                    default: res_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin : row_side
        int         rand_rows;
        int         grid_len;
        int         waited;
        bit         still_done;
        row_style_t style;
        errors     = 0;
        prev2_row  = '0;
        prev1_row  = '0;
        rows_in    = 0;
        grid_total = 0;
        burst_left = 0;
        hold_req   = 1'b0;
        rst_n           <= 1'b0;
        row_ch.valid    <= 1'b0;
        row_ch.row_bits <= '0;
        row_ch.last_row <= 1'b0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_row(dir_rows[i].bits, dir_rows[i].last);
            if (dir_rows[i].typed)
            begin
                void'(next_gen_q.pop_back());
                next_gen_q.push_back(dir_rows[i].want);
            end
            pace();
        end

        // receiver holds off while rows keep coming, so the block backs up
        hold_req   = 1'b1;
        rand_rows  = 0;
        still_done = 1'b0;
        while (rand_rows < RANDOM_ROWS)
        begin
            if (!still_done && rand_rows >= RANDOM_ROWS / 2)
            begin
                // taller grid of still blocks with a steadily growing total
                for (int r = 0; r < STILL_ROWS; r++)
                begin
                    send_row((r % 3 != 2) ? BLOCK_ROW : '0, r == STILL_ROWS - 1);
                    pace();
                end
                still_done = 1'b1;
            end
            case ($urandom_range(0, 15))
                0, 1:    grid_len = 1;
                2:       grid_len = $urandom_range(13, 40);
                default: grid_len = $urandom_range(2, 12);
            endcase
            style = row_style_t'($urandom_range(0, 3));
            for (int r = 0; r < grid_len; r++)
            begin
                send_row(($urandom_range(0, 7) == 0) ? random_row(ROW_EXTREME)
                                                     : random_row(style),
                         r == grid_len - 1);
                pace();
                rand_rows++;
            end
        end
        row_ch.valid <= 1'b0;

        waited = 0;
        while (next_gen_q.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10)
            @(posedge clk);
        if (next_gen_q.size() != 0)
            report($sformatf("%0d beats never arrived", next_gen_q.size()));
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
